FILE: rtl/rstd_pkg.sv
// Shared constants, codes and types for the regression slope trend detector.
// No dependencies; compiled first.
package rstd_pkg;

	// Window geometry
	localparam int WIN_LEN  = 64;
	localparam int ADDR_W   = 6;
	localparam int FILL_W   = 7;

	// Input and register widths
	localparam int SAMPLE_W = 24;
	localparam int EXT_W    = SAMPLE_W + 1;
	localparam int CTS_W    = 24;
	localparam logic [CTS_W-1:0] CTS_RESET = 24'd261890;

	// Running sums over the window
	localparam int SUM_W    = 31;   // sum of samples
	localparam int WSUM_W   = 37;   // sum of samples weighted by age
	localparam int SQ_W     = 54;   // sum of squares

	// Shared multiplier
	localparam int MUL_W    = 33;
	localparam int PROD_W   = 66;

	// Significance test datapath
	localparam int A_W      = 42;   // N*Sxy
	localparam int BB_W     = 59;   // N*Syy
	localparam int BB5_W    = 62;   // 5*BB
	localparam int BB85_W   = 66;   // 85*BB
	localparam int SXB_W    = 80;   // N*Sxx * N*Syy
	localparam int A2_W     = 82;   // (N*Sxy)^2
	localparam int D_W      = 80;   // SXB - A2
	localparam int CMP_W    = 104;  // both sides of the final compare

	// Opcodes
	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// Trend codes
	typedef logic [1:0] trend_t;
	localparam trend_t TREND_UNKNOWN = 2'd0;
	localparam trend_t TREND_RISING  = 2'd1;
	localparam trend_t TREND_STEADY  = 2'd2;
	localparam trend_t TREND_FALLING = 2'd3;

	// Access to the sample ring
	typedef struct packed {
		logic                       rd;
		logic                       wr;
		logic [ADDR_W-1:0]          addr;
		logic signed [SAMPLE_W-1:0] wdata;
	} ring_req_t;

endpackage

FILE: rtl/rstd_if.sv
// Channel interfaces: sample items, trend results, threshold register writes.
// Depends on rstd_pkg.
interface rstd_item_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 opcode;
	logic signed [rstd_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output opcode, output sample, input ready);
	modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface rstd_result_if;
	logic             valid;
	logic             ready;
	rstd_pkg::trend_t trend;

	modport source (output valid, output trend, input ready);
	modport sink   (input valid, input trend, output ready);
endinterface

interface rstd_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [rstd_pkg::CTS_W-1:0]    critical_t_squared;

	modport source (output valid, output critical_t_squared, input ready);
	modport sink   (input valid, input critical_t_squared, output ready);
endinterface

FILE: rtl/rstd_ring.sv
// Sample ring: single-port synchronous memory with registered read.
// Depends on rstd_pkg.
module rstd_ring (
	input  logic                                 clk,
	input  rstd_pkg::ring_req_t                  req,
	output logic signed [rstd_pkg::SAMPLE_W-1:0] rdata
);

	logic signed [rstd_pkg::SAMPLE_W-1:0] mem [rstd_pkg::WIN_LEN];
	logic signed [rstd_pkg::SAMPLE_W-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/regression_slope_trend_detector_top.sv
// A clear goes straight to the emit state; a push into a filling window updates the sums and then emits.
// A push into a full window also runs the significance test: the sequencer walks 8 products through
// one shared 33x33 multiplier. Input is taken only when the sequencer idles, and the sequencer
// waits in its emit state while the result register stays occupied.
// Reset (arst_n low): counts and sums clear, threshold returns to 261890; the sample memory keeps
// its contents; values read while the window fills are ignored. Depends on rstd_pkg, rstd_if, rstd_ring.
module regression_slope_trend_detector_top (
	input  logic          clk,
	input  logic          arst_n,
	rstd_item_if.sink     item,
	rstd_cfg_if.sink      cfg,
	rstd_result_if.source result
);

	// Sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_UPD  = 4'd1;
	localparam logic [3:0] ST_SQ   = 4'd2;
	localparam logic [3:0] ST_BB   = 4'd3;
	localparam logic [3:0] ST_A1   = 4'd4;
	localparam logic [3:0] ST_A2   = 4'd5;
	localparam logic [3:0] ST_A3   = 4'd6;
	localparam logic [3:0] ST_DIFF = 4'd7;
	localparam logic [3:0] ST_R1   = 4'd8;
	localparam logic [3:0] ST_R2   = 4'd9;
	localparam logic [3:0] ST_R3   = 4'd10;
	localparam logic [3:0] ST_R4   = 4'd11;
	localparam logic [3:0] ST_EMIT = 4'd12;

	logic [3:0]                                state_q;
	logic [rstd_pkg::FILL_W-1:0]               fill_q;
	logic [rstd_pkg::ADDR_W-1:0]               head_q;
	logic signed [rstd_pkg::SUM_W-1:0]         sy_q;
	logic signed [rstd_pkg::WSUM_W-1:0]        wsum_q;
	logic [rstd_pkg::SQ_W-1:0]                 sqsum_q;
	logic [rstd_pkg::CTS_W-1:0]                cts_q;
	logic                                      out_valid_q;
	rstd_pkg::trend_t                          out_trend_q;

	// Payload registers
	logic signed [rstd_pkg::SAMPLE_W-1:0]      samp_q;
	logic                                      unknown_q;
	logic signed [rstd_pkg::A_W-1:0]           a_q;
	logic [rstd_pkg::BB_W-1:0]                 bb_q;
	logic [rstd_pkg::BB5_W-1:0]                bb5_q;
	logic [rstd_pkg::BB85_W-1:0]               bb85_q;
	logic [rstd_pkg::SXB_W-1:0]                sxb_q;
	logic [rstd_pkg::A2_W-1:0]                 a2_q;
	logic [rstd_pkg::D_W-1:0]                  d_q;
	logic [rstd_pkg::CMP_W-1:0]                lhs_q;
	logic [rstd_pkg::CMP_W-1:0]                rhs_q;
	logic signed [rstd_pkg::PROD_W-1:0]        prod_q;

	logic                                      in_xfer;
	logic                                      full;
	logic                                      out_free;
	rstd_pkg::ring_req_t                       ring_req;
	logic signed [rstd_pkg::SAMPLE_W-1:0]      ring_rdata;
	logic signed [rstd_pkg::SAMPLE_W-1:0]      y_old;
	logic signed [rstd_pkg::EXT_W-1:0]         y_dif;
	logic signed [rstd_pkg::EXT_W-1:0]         y_sum;
	logic signed [rstd_pkg::A_W-1:0]           sy_ext;
	logic signed [rstd_pkg::BB_W+1:0]          bb_dif;
	logic [rstd_pkg::A2_W-1:0]                 sxb_ext;
	logic signed [rstd_pkg::MUL_W-1:0]         mul_a;
	logic signed [rstd_pkg::MUL_W-1:0]         mul_b;
	rstd_pkg::trend_t                          trend_calc;

	// Handshakes
	assign item.ready   = (state_q == ST_IDLE);
	assign in_xfer      = item.valid && item.ready;
	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.trend = out_trend_q;
	assign out_free     = !out_valid_q || result.ready;

	assign full = (fill_q == rstd_pkg::FILL_W'(rstd_pkg::WIN_LEN));

	// Ring access: read the oldest slot on transfer, overwrite it in the following cycle
	assign ring_req.rd    = in_xfer && (item.opcode == rstd_pkg::OP_PUSH);
	assign ring_req.wr    = (state_q == ST_UPD);
	assign ring_req.addr  = head_q;
	assign ring_req.wdata = samp_q;

	rstd_ring u_ring (
		.clk   (clk),
		.req   (ring_req),
		.rdata (ring_rdata)
	);

	// Sample leaving the window; none while filling
	assign y_old = full ? ring_rdata : '0;
	assign y_dif = rstd_pkg::EXT_W'(samp_q) - rstd_pkg::EXT_W'(y_old);
	assign y_sum = rstd_pkg::EXT_W'(samp_q) + rstd_pkg::EXT_W'(y_old);

	// Centered-sum helpers
	assign sy_ext  = rstd_pkg::A_W'(sy_q);
	assign bb_dif  = $signed({1'b0, sqsum_q, 6'b0})
		- $signed({2'b0, prod_q[rstd_pkg::BB_W-1:0]});
	assign sxb_ext = rstd_pkg::A2_W'(sxb_q);

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_UPD: begin
				// new^2 - old^2 as (new - old) * (new + old)
				mul_a = rstd_pkg::MUL_W'(y_dif);
				mul_b = rstd_pkg::MUL_W'(y_sum);
			end
			ST_SQ: begin
				mul_a = rstd_pkg::MUL_W'(sy_q);
				mul_b = rstd_pkg::MUL_W'(sy_q);
			end
			ST_BB: begin
				mul_a = {1'b0, a_q[31:0]};
				mul_b = {1'b0, a_q[31:0]};
			end
			ST_A1: begin
				mul_a = {1'b0, a_q[31:0]};
				mul_b = rstd_pkg::MUL_W'($signed(a_q[rstd_pkg::A_W-1:32]));
			end
			ST_A2: begin
				mul_a = rstd_pkg::MUL_W'($signed(a_q[rstd_pkg::A_W-1:32]));
				mul_b = rstd_pkg::MUL_W'($signed(a_q[rstd_pkg::A_W-1:32]));
			end
			ST_R1: begin
				mul_a = {1'b0, d_q[31:0]};
				mul_b = {9'b0, cts_q};
			end
			ST_R2: begin
				mul_a = {1'b0, d_q[63:32]};
				mul_b = {9'b0, cts_q};
			end
			ST_R3: begin
				mul_a = {17'b0, d_q[rstd_pkg::D_W-1:64]};
				mul_b = {9'b0, cts_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Registered product
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Final decision
	always_comb begin
		priority if (unknown_q) begin
			trend_calc = rstd_pkg::TREND_UNKNOWN;
		end else if (lhs_q > rhs_q) begin
			trend_calc = a_q[rstd_pkg::A_W-1] ? rstd_pkg::TREND_FALLING
				: rstd_pkg::TREND_RISING;
		end else begin
			trend_calc = rstd_pkg::TREND_STEADY;
		end
	end

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cts_q <= rstd_pkg::CTS_RESET;
		end else if (cfg.valid && cfg.ready) begin
			cts_q <= cfg.critical_t_squared;
		end
	end

	// Sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			head_q      <= '0;
			sy_q        <= '0;
			wsum_q      <= '0;
			sqsum_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Result register: load on emit, free on transfer
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (item.opcode == rstd_pkg::OP_CLEAR) begin
							fill_q  <= '0;
							head_q  <= '0;
							sy_q    <= '0;
							wsum_q  <= '0;
							sqsum_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					// age-weighted sum: every kept sample ages by one
					sy_q   <= sy_q + rstd_pkg::SUM_W'(samp_q) - rstd_pkg::SUM_W'(y_old);
					wsum_q <= wsum_q + rstd_pkg::WSUM_W'(sy_q)
						- (rstd_pkg::WSUM_W'(y_old) <<< 6);
					head_q <= head_q + 1'b1;
					if (!full) begin
						fill_q <= fill_q + 1'b1;
					end
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					sqsum_q <= sqsum_q + prod_q[rstd_pkg::SQ_W-1:0];
					state_q <= full ? ST_BB : ST_EMIT;
				end
				ST_BB:   state_q <= ST_A1;
				ST_A1:   state_q <= ST_A2;
				ST_A2:   state_q <= ST_A3;
				ST_A3:   state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_R1;
				ST_R1:   state_q <= ST_R2;
				ST_R2:   state_q <= ST_R3;
				ST_R3:   state_q <= ST_R4;
				ST_R4:   state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				unknown_q <= 1'b1;
				if (in_xfer) begin
					samp_q <= item.sample;
				end
			end
			ST_SQ: begin
				unknown_q <= !full;
				// N*Sxy = 2016*Sy - 64*W with W the age-weighted sum
				a_q <= (sy_ext <<< 11) - (sy_ext <<< 5)
					- (rstd_pkg::A_W'(wsum_q) <<< 6);
			end
			ST_BB: begin
				// N*Syy = 64*sum(y^2) - Sy^2, never below zero
				bb_q <= bb_dif[rstd_pkg::BB_W+1] ? '0 : bb_dif[rstd_pkg::BB_W-1:0];
			end
			ST_A1: begin
				a2_q  <= rstd_pkg::A2_W'(prod_q);
				bb5_q <= rstd_pkg::BB5_W'(bb_q) + (rstd_pkg::BB5_W'(bb_q) << 2);
			end
			ST_A2: begin
				// cross term counted twice
				a2_q   <= a2_q + (rstd_pkg::A2_W'(prod_q) << 33);
				bb85_q <= rstd_pkg::BB85_W'(bb5_q) + (rstd_pkg::BB85_W'(bb5_q) << 4);
			end
			ST_A3: begin
				a2_q  <= a2_q + (rstd_pkg::A2_W'(prod_q) << 64);
				// N*Sxx = 1397760 = 1365 << 10, 1365 = 85*16 + 5
				sxb_q <= (rstd_pkg::SXB_W'(bb85_q) << 14) + (rstd_pkg::SXB_W'(bb5_q) << 10);
			end
			ST_DIFF: begin
				d_q   <= (sxb_ext >= a2_q) ? rstd_pkg::D_W'(sxb_ext - a2_q) : '0;
				// a2 * (N-2) * 2^16 with N-2 = 62 = 64 - 2
				lhs_q <= (rstd_pkg::CMP_W'(a2_q) << 22) - (rstd_pkg::CMP_W'(a2_q) << 17);
			end
			ST_R2: begin
				rhs_q <= rstd_pkg::CMP_W'(prod_q[63:0]);
			end
			ST_R3: begin
				rhs_q <= rhs_q + (rstd_pkg::CMP_W'(prod_q[63:0]) << 32);
			end
			ST_R4: begin
				rhs_q <= rhs_q + (rstd_pkg::CMP_W'(prod_q[63:0]) << 64);
			end
			ST_EMIT: begin
				if (out_free) begin
					out_trend_q <= trend_calc;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
